// ===== rtl/char_class_range_set_match_defines.svh =====
// Assertion macros for the character class range set block
`ifndef CHAR_CLASS_RANGE_SET_MATCH_DEFINES_SVH
`define CHAR_CLASS_RANGE_SET_MATCH_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define CCRS_AST_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication, checked while out of reset
`define CCRS_AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== rtl/ccrs_pkg.sv =====
// Shared types, codes and helpers for the range set block
package ccrs_pkg;

    typedef logic [20:0] cp_t;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_PREPARE = 2'd1,
        OP_MATCH   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_UNPREP   = 2'd2,
        ST_INVALID  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CM_HOLD  = 2'd0,
        CM_MARK  = 2'd1,
        CM_SORT  = 2'd2,
        CM_SHIFT = 2'd3
    } cell_mode_t;

    typedef struct packed {
        logic vld;
        cp_t  f;
        cp_t  l;
    } entry_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       phase;
    } cell_ctrl_t;

    localparam cp_t CP_MAX  = 21'h10FFFF;
    localparam cp_t SURR_LO = 21'h00D800;
    localparam cp_t SURR_HI = 21'h00DFFF;

    function automatic logic cp_valid(input cp_t c);
        return (c <= CP_MAX) && ((c < SURR_LO) || (c > SURR_HI));
    endfunction

    // empty entries order after every filled one
    function automatic logic ent_less(input entry_t a, input entry_t b);
        return a.vld && (!b.vld || (a.f < b.f) || ((a.f == b.f) && (a.l < b.l)));
    endfunction

endpackage

// ===== rtl/ccrs_if.sv =====
// Valid/ready channel interfaces for request and result items
interface ccrs_in_if;
    import ccrs_pkg::*;
    logic valid;
    logic ready;
    logic [1:0] opcode;
    cp_t range_first;
    cp_t range_last;
    cp_t character;
    modport source (output valid, output opcode, output range_first,
                    output range_last, output character, input ready);
    modport sink   (input valid, input opcode, input range_first,
                    input range_last, input character, output ready);
endinterface

interface ccrs_out_if;
    logic valid;
    logic ready;
    logic is_member;
    logic [6:0] stored_ranges;
    logic single_char_class;
    logic [1:0] status;
    modport source (output valid, output is_member, output stored_ranges,
                    output single_char_class, output status, input ready);
    modport sink   (input valid, input is_member, input stored_ranges,
                    input single_char_class, input status, output ready);
endinterface

// ===== rtl/char_class_range_set_match.sv =====
// Range set engine: add loads the next free cell, match makes one lap of the chain,
// prepare runs mark, transposition sort, merge lap, a fix step for cell 0, then sort again.
// The sort and lap lengths follow the cell count, not the fill.
// One item at a time; the next item is taken in the cycle the waiting result leaves.
// Reset (rst_n low, asynchronous) empties the set and marks it prepared; range cells are
// not cleared.
module char_class_range_set_match
    import ccrs_pkg::*;
#(
    parameter int MAX_RANGES = 64
) (
    input  logic  clk,
    input  logic  rst_n,
    ccrs_in_if.sink    in_ch,
    ccrs_out_if.source out_ch
);

    localparam int CW = $clog2(MAX_RANGES + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MARK  = 7'b0000010,
        S_SORT1 = 7'b0000100,
        S_MERGE = 7'b0001000,
        S_MFIX  = 7'b0010000,
        S_SORT2 = 7'b0100000,
        S_MATCH = 7'b1000000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           prep_reg, prep_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           phase_reg, phase_next;
    logic           resp_reg, resp_next;
    logic           ov_reg, ov_next;
    logic           hit_reg, hit_next;
    logic           have_reg, have_next;
    logic [CW-1:0]  mcnt_reg, mcnt_next;
    entry_t         rep_reg, rep_next;
    cp_t            chr_reg, chr_next;
    logic           mem_reg, mem_next;
    logic [1:0]     st_reg, st_next;
    logic           sng_reg, sng_next;
    logic [CW-1:0]  sc_reg, sc_next;

    cell_ctrl_t     ctrl;
    entry_t         q [MAX_RANGES];
    entry_t         tail;
    entry_t         load_ent;
    logic           add_load;
    logic           fix_load;
    entry_t         head;
    logic           acc;
    logic           last_cnt;
    logic           single_now;
    logic [21:0]    rep_l_inc;
    logic [CW+6:0]  sc_wide;

    assign head       = q[0];
    assign acc        = in_ch.valid && in_ch.ready;
    assign last_cnt   = (cnt_reg == CW'(MAX_RANGES - 1));
    assign single_now = (count_reg == CW'(1)) && (head.f == head.l);
    assign rep_l_inc  = {1'b0, rep_reg.l} + 22'd1;
    assign in_ch.ready = (state_reg == S_IDLE) && !resp_reg && (!ov_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        prep_next  = prep_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        resp_next  = 1'b0;
        ov_next    = ov_reg && !out_ch.ready;
        hit_next   = hit_reg;
        have_next  = have_reg;
        mcnt_next  = mcnt_reg;
        rep_next   = rep_reg;
        chr_next   = chr_reg;
        mem_next   = mem_reg;
        st_next    = st_reg;
        sng_next   = sng_reg;
        sc_next    = sc_reg;
        ctrl.mode  = CM_HOLD;
        ctrl.phase = phase_reg;
        tail       = head;
        add_load   = 1'b0;
        fix_load   = 1'b0;
        load_ent   = rep_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (resp_reg)
                begin
                    // long op finished: publish from current state
                    ov_next  = 1'b1;
                    mem_next = hit_reg;
                    st_next  = ST_OK;
                    sng_next = single_now;
                    sc_next  = count_reg;
                end
                else if (acc)
                begin
                    ov_next  = 1'b1;
                    mem_next = 1'b0;
                    st_next  = ST_OK;
                    sng_next = single_now;
                    sc_next  = count_reg;
                    cnt_next = '0;
                    phase_next = 1'b0;
                    case (op_t'(in_ch.opcode))
                        OP_ADD:
                        begin
                            if (!cp_valid(in_ch.range_first) || !cp_valid(in_ch.range_last)
                                || (in_ch.range_first > in_ch.range_last))
                            begin
                                st_next = ST_INVALID;
                            end
                            else if (count_reg >= CW'(MAX_RANGES))
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                add_load   = 1'b1;
                                load_ent   = '{vld: 1'b1, f: in_ch.range_first,
                                               l: in_ch.range_last};
                                count_next = count_reg + CW'(1);
                                prep_next  = 1'b0;
                                sc_next    = count_reg + CW'(1);
                                sng_next   = (count_reg == '0)
                                             && (in_ch.range_first == in_ch.range_last);
                            end
                        end
                        OP_PREPARE:
                        begin
                            if (!prep_reg)
                            begin
                                ov_next    = 1'b0;
                                state_next = S_MARK;
                                hit_next   = 1'b0;
                            end
                        end
                        OP_MATCH:
                        begin
                            if (!prep_reg)
                            begin
                                st_next = ST_UNPREP;
                            end
                            else
                            begin
                                ov_next    = 1'b0;
                                hit_next   = 1'b0;
                                chr_next   = in_ch.character;
                                state_next = S_MATCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MARK:
            begin
                ctrl.mode  = CM_MARK;
                state_next = S_SORT1;
            end
            S_SORT1, S_SORT2:
            begin
                ctrl.mode  = CM_SORT;
                phase_next = !phase_reg;
                cnt_next   = cnt_reg + CW'(1);
                if (last_cnt)
                begin
                    cnt_next   = '0;
                    phase_next = 1'b0;
                    have_next  = 1'b0;
                    mcnt_next  = '0;
                    if (state_reg == S_SORT1)
                    begin
                        state_next = S_MERGE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        prep_next  = 1'b1;
                        resp_next  = 1'b1;
                    end
                end
            end
            S_MERGE:
            begin
                ctrl.mode = CM_SHIFT;
                tail      = '{vld: 1'b0, f: head.f, l: head.l};
                if (head.vld)
                begin
                    if (!have_reg)
                    begin
                        have_next = 1'b1;
                        rep_next  = head;
                    end
                    else if ({1'b0, head.f} <= rep_l_inc)
                    begin
                        if (head.l > rep_reg.l)
                        begin
                            rep_next.l = head.l;
                        end
                    end
                    else
                    begin
                        // emit the finished range, start a new one
                        tail      = rep_reg;
                        rep_next  = head;
                        mcnt_next = mcnt_reg + CW'(1);
                    end
                end
                cnt_next = cnt_reg + CW'(1);
                if (last_cnt)
                begin
                    cnt_next   = '0;
                    state_next = S_MFIX;
                end
            end
            S_MFIX:
            begin
                // the first lap step left cell 0 empty: park the open range there
                fix_load   = 1'b1;
                load_ent   = rep_reg;
                count_next = mcnt_reg + CW'(1);
                state_next = S_SORT2;
            end
            S_MATCH:
            begin
                ctrl.mode = CM_SHIFT;
                tail      = head;
                // cells are never marked while the set is still empty
                if ((count_reg != '0) && head.vld && (chr_reg >= head.f)
                    && (chr_reg <= head.l))
                begin
                    hit_next = 1'b1;
                end
                cnt_next = cnt_reg + CW'(1);
                if (last_cnt)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                    resp_next  = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    for (genvar i = 0; i < MAX_RANGES; i++)
    begin : g_cell
        entry_t left_n;
        entry_t right_n;
        logic   ld;
        assign left_n  = (i == 0) ? q[i] : q[(i == 0) ? 0 : i - 1];
        assign right_n = (i == MAX_RANGES - 1)
                         ? ((ctrl.mode == CM_SHIFT) ? tail : q[i])
                         : q[(i == MAX_RANGES - 1) ? i : i + 1];
        assign ld = (add_load && (count_reg == CW'(i))) || (fix_load && (i == 0));
        ccrs_cell #(
            .ODD (1'((i % 2)))
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .load_en  (ld),
            .load_ent (load_ent),
            .mark_vld (count_reg > CW'(i)),
            .left     (left_n),
            .right    (right_n),
            .q        (q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            prep_reg  <= 1'b1;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
            resp_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            have_reg  <= 1'b0;
            mcnt_reg  <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            prep_reg  <= prep_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            resp_reg  <= resp_next;
            ov_reg    <= ov_next;
            have_reg  <= have_next;
            mcnt_reg  <= mcnt_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rep_reg <= rep_next;
        chr_reg <= chr_next;
        mem_reg <= mem_next;
        st_reg  <= st_next;
        sng_reg <= sng_next;
        sc_reg  <= sc_next;
    end

    assign sc_wide                  = {7'd0, sc_reg};
    assign out_ch.valid             = ov_reg;
    assign out_ch.is_member         = mem_reg;
    assign out_ch.stored_ranges     = sc_wide[6:0];
    assign out_ch.single_char_class = sng_reg;
    assign out_ch.status            = st_reg;

endmodule

// ===== rtl/ccrs_cell.sv =====
// One cell of the range chain: holds a range, loads, marks, sorts and shifts with neighbors
module ccrs_cell
    import ccrs_pkg::*;
#(
    parameter bit ODD = 1'b0
) (
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       load_en,
    input  entry_t     load_ent,
    input  logic       mark_vld,
    input  entry_t     left,
    input  entry_t     right,
    output entry_t     q
);

    entry_t ent_reg;
    entry_t ent_next;

    always_comb
    begin
        ent_next = ent_reg;
        if (load_en)
        begin
            ent_next = load_ent;
        end
        else
        begin
            case (ctrl.mode)
                CM_MARK:  ent_next.vld = mark_vld;
                CM_SORT:
                begin
                    if (ODD == ctrl.phase)
                    begin
                        // lower of the pair: keep the smaller
                        if (ent_less(right, ent_reg))
                        begin
                            ent_next = right;
                        end
                    end
                    else if (ent_less(ent_reg, left))
                    begin
                        ent_next = left;
                    end
                end
                CM_SHIFT: ent_next = right;
                default:  ent_next = ent_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign q = ent_reg;

endmodule

// ===== rtl/ccrs_checker.sv =====
// Port-level checks for the range set block, bound to the top level
`include "char_class_range_set_match_defines.svh"

module ccrs_checker
    import ccrs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       is_member,
    input logic [6:0] stored_ranges,
    input logic       single_char_class,
    input logic [1:0] status
);

    `CCRS_AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `CCRS_AST_NOW(a_fail_no_member, out_valid && (status != ST_OK), !is_member)
    `CCRS_AST_NOW(a_single_count, out_valid && single_char_class, stored_ranges == 7'd1)
    `CCRS_AST_NOW(a_member_nonempty, out_valid && is_member, stored_ranges != 7'd0)

endmodule

bind char_class_range_set_match ccrs_checker u_ccrs_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .is_member         (out_ch.is_member),
    .stored_ranges     (out_ch.stored_ranges),
    .single_char_class (out_ch.single_char_class),
    .status            (out_ch.status)
);
